// ===== design/xfrst_pkg.sv =====
// ----------------------------------------------------------------------------
// XOR frame receiver package
// Result codes, table codes, command bytes and the command-to-table mapping.
// ----------------------------------------------------------------------------
package xfrst_pkg;

  // Result kinds reported on the output channel.
  typedef enum logic [2:0] {
    KIND_STORED   = 3'd0,
    KIND_BAD_ID   = 3'd1,
    KIND_BAD_SUM  = 3'd2,
    KIND_ABORTED  = 3'd3,
    KIND_READ     = 3'd4
  } kind_e;

  // Table codes.
  localparam logic [1:0] TBL_LIGHT      = 2'd0;
  localparam logic [1:0] TBL_TIMEOUT    = 2'd1;
  localparam logic [1:0] TBL_BRIGHTNESS = 2'd2;
  localparam logic [1:0] TBL_STATE      = 2'd3;

  // Input actions.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Protocol bytes.
  localparam logic [7:0] HEADER_BYTE    = 8'hAA;
  localparam logic [7:0] CMD_LIGHT_A    = 8'hB0;
  localparam logic [7:0] CMD_LIGHT_B    = 8'hB1;
  localparam logic [7:0] CMD_TIMEOUT    = 8'hB2;
  localparam logic [7:0] CMD_LIGHT_C    = 8'hB3;
  localparam logic [7:0] CMD_BRIGHTNESS = 8'hB5;

  // One result item.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] module_id;
    logic [7:0] command_byte;
    logic [7:0] parameter_byte;
    logic [1:0] table_hit;
  } result_t;

  // Maps a command byte to the table that keeps it.
  function automatic logic [1:0] table_of(logic [7:0] cmd);
    logic [1:0] tbl;
    if (cmd == CMD_LIGHT_A || cmd == CMD_LIGHT_B || cmd == CMD_LIGHT_C) begin
      tbl = TBL_LIGHT;
    end else if (cmd == CMD_TIMEOUT) begin
      tbl = TBL_TIMEOUT;
    end else if (cmd == CMD_BRIGHTNESS) begin
      tbl = TBL_BRIGHTNESS;
    end else begin
      tbl = TBL_STATE;
    end
    return tbl;
  endfunction

endpackage

// ===== design/xfrst_in_if.sv =====
// ----------------------------------------------------------------------------
// XOR frame receiver input channel
// Valid/ready channel carrying one received byte or one table read request.
// ----------------------------------------------------------------------------
interface xfrst_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_in;
  logic [1:0] read_table;
  logic [3:0] read_module;

  modport source (output valid, output action, output byte_in, output read_table,
                  output read_module, input ready);
  modport sink   (input valid, input action, input byte_in, input read_table,
                  input read_module, output ready);
endinterface

// ===== design/xfrst_out_if.sv =====
// ----------------------------------------------------------------------------
// XOR frame receiver output channel
// Valid/ready channel carrying one frame report or one read reply.
// ----------------------------------------------------------------------------
interface xfrst_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] module_id;
  logic [7:0] command_byte;
  logic [7:0] parameter_byte;
  logic [1:0] table_hit;

  modport source (output valid, output kind, output module_id, output command_byte,
                  output parameter_byte, output table_hit, input ready);
  modport sink   (input valid, input kind, input module_id, input command_byte,
                  input parameter_byte, input table_hit, output ready);
endinterface

// ===== design/xfrst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module xfrst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/xor_frame_receiver_status_table.sv =====
// ----------------------------------------------------------------------------
// XOR frame receiver with module status tables
// Cuts reply bytes into XOR-checked frames and keeps per-module status.
// ----------------------------------------------------------------------------
// Usage:
// The input channel in_i carries either a received byte (action 0) or a
// request to read one status table entry (action 1). The block sustains one
// item per clock while out_o keeps taking results. A frame opens at header
// 0xAA and closes with its XOR checksum byte, byte FRAME_LENGTH of the frame.
// The closing byte, a header that cuts an open frame short, and every read
// request each produce one result on out_o; other bytes produce none.
// A result passes through the status RAM read stage and then the output
// register, which holds it until out_o takes it. Good frames with an ID of
// 1..MODULE_COUNT write command and parameter into the status RAM in the
// cycle of their transfer, so a read that follows directly sees them.
// Reset clears the frame tracker and the per-entry valid flags at once;
// every table entry then reads as empty, and no clearing pass is needed.
// When the receiver of out_o stalls, the held result waits in the output
// register while the RAM stage still takes one more item; only when both are
// full does in_i.ready drop, and it rises again in the cycle out_o is taken.
// ----------------------------------------------------------------------------
module xor_frame_receiver_status_table #(
  parameter int MODULE_COUNT = 8,
  parameter int FRAME_LENGTH = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  xfrst_in_if.sink          in_i,
  xfrst_out_if.source       out_o
);

  localparam int ENTRIES = 4 * MODULE_COUNT;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW      = $clog2(FRAME_LENGTH);

  // Handshake and pipeline control.
  logic in_xfer;
  logic s1_adv;
  logic in_ready;

  // Frame tracker. Only the running XOR and bytes 2..4 need to be kept.
  logic          open_q,  open_d;
  logic [PW-1:0] pos_q,   pos_d;
  logic [7:0]    xor_q,   xor_d;
  logic [7:0]    id_q,    id_d;
  logic [7:0]    cmd_q,   cmd_d;
  logic [7:0]    par_q,   par_d;

  // Frame result of the current byte.
  logic                 frm_res;
  xfrst_pkg::result_t   frm_item;
  logic [1:0]           frm_tbl;
  logic                 id_ok;

  // Status RAM access and valid flags.
  logic               ram_we;
  logic [AW-1:0]      wr_addr;
  logic               ram_re;
  logic [AW-1:0]      rd_addr;
  logic [15:0]        ram_rdata;
  logic               rd_in_range;
  logic [ENTRIES-1:0] valid_q, valid_d;

  // Stage 1: RAM read stage.
  logic               s1_valid_q, s1_valid_d;
  logic               s1_read_q;
  logic               s1_hit_q;
  xfrst_pkg::result_t s1_q;
  xfrst_pkg::result_t s1_item;

  // Output register.
  logic               out_valid_q, out_valid_d;
  xfrst_pkg::result_t out_q;

  // The RAM stage advances when the output register is free or being emptied.
  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_xfer  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // --------------------------------------------------------------------------
  // Frame tracker next state and frame results.
  // --------------------------------------------------------------------------
  assign frm_tbl = xfrst_pkg::table_of(cmd_q);
  assign id_ok   = (id_q != 8'd0) && (32'(id_q) <= MODULE_COUNT);

  always_comb begin
    open_d  = open_q;
    pos_d   = pos_q;
    xor_d   = xor_q;
    id_d    = id_q;
    cmd_d   = cmd_q;
    par_d   = par_q;
    frm_res = 1'b0;
    ram_we  = 1'b0;
    frm_item = '{kind: xfrst_pkg::KIND_ABORTED, module_id: id_q, command_byte: cmd_q,
                 parameter_byte: par_q, table_hit: xfrst_pkg::TBL_LIGHT};

    if (in_xfer && in_i.action == xfrst_pkg::ACT_BYTE) begin
      if (in_i.byte_in == xfrst_pkg::HEADER_BYTE) begin
        // A header always opens a fresh frame; an open one is reported aborted.
        frm_res = open_q;
        open_d  = 1'b1;
        pos_d   = PW'(1);
        xor_d   = in_i.byte_in;
        id_d    = 8'd0;
        cmd_d   = 8'd0;
        par_d   = 8'd0;
      end else if (open_q) begin
        if (32'(pos_q) < FRAME_LENGTH - 1) begin
          xor_d = xor_q ^ in_i.byte_in;
          pos_d = pos_q + PW'(1);
          if (32'(pos_q) == 2) begin
            id_d = in_i.byte_in;
          end
          if (32'(pos_q) == 3) begin
            cmd_d = in_i.byte_in;
          end
          if (32'(pos_q) == 4) begin
            par_d = in_i.byte_in;
          end
        end else begin
          // Checksum byte closes the frame.
          frm_res = 1'b1;
          open_d  = 1'b0;
          pos_d   = '0;
          if (xor_q != in_i.byte_in) begin
            frm_item.kind = xfrst_pkg::KIND_BAD_SUM;
          end else if (id_ok) begin
            frm_item.kind      = xfrst_pkg::KIND_STORED;
            frm_item.table_hit = frm_tbl;
            ram_we             = 1'b1;
          end else begin
            frm_item.kind = xfrst_pkg::KIND_BAD_ID;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      open_q <= open_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xor_q <= xor_d;
    id_q  <= id_d;
    cmd_q <= cmd_d;
    par_q <= par_d;
  end

  // --------------------------------------------------------------------------
  // Status RAM: table-major layout, entry = table * MODULE_COUNT + ID - 1.
  // A write and a read never share a cycle, since each item does one or the
  // other, so a read right after a store sees the stored data.
  // --------------------------------------------------------------------------
  assign wr_addr = AW'(32'(frm_tbl) * 32'(MODULE_COUNT) + 32'(id_q) - 32'd1);
  assign rd_addr = AW'(32'(in_i.read_table) * 32'(MODULE_COUNT)
                       + 32'(in_i.read_module) - 32'd1);
  assign rd_in_range = (in_i.read_module != 4'd0)
                       && (32'(in_i.read_module) <= MODULE_COUNT);
  assign ram_re = in_xfer && in_i.action == xfrst_pkg::ACT_READ;

  xfrst_ram #(
    .WIDTH (16),
    .DEPTH (ENTRIES)
  ) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i ({cmd_q, par_q}),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    valid_d = valid_q;
    if (ram_we) begin
      valid_d[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1. The RAM read data is combined here; the RAM holds its output
  // while the stage is stalled because no new read is issued then.
  // --------------------------------------------------------------------------
  assign s1_valid_d = (s1_valid_q && !s1_adv) || (in_xfer && (ram_re || frm_res));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_read_q <= ram_re;
      s1_hit_q  <= rd_in_range && valid_q[rd_addr];
      if (ram_re) begin
        s1_q <= '{kind: xfrst_pkg::KIND_READ, module_id: {4'd0, in_i.read_module},
                  command_byte: 8'd0, parameter_byte: 8'd0,
                  table_hit: in_i.read_table};
      end else begin
        s1_q <= frm_item;
      end
    end
  end

  always_comb begin
    s1_item = s1_q;
    if (s1_read_q) begin
      if (s1_hit_q) begin
        s1_item.command_byte   = ram_rdata[15:8];
        s1_item.parameter_byte = ram_rdata[7:0];
      end else begin
        s1_item.module_id = 8'd0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  assign out_valid_d = s1_adv || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= s1_item;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_q.kind;
  assign out_o.module_id      = out_q.module_id;
  assign out_o.command_byte   = out_q.command_byte;
  assign out_o.parameter_byte = out_q.parameter_byte;
  assign out_o.table_hit      = out_q.table_hit;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // An open frame always has at least its header counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> pos_q != '0)
    else $error("frame open with zero byte count");

  // A stored frame marks its table entry valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(wr_addr)])
    else $error("stored entry not marked valid");

  // Every read request reaches the RAM stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (s1_valid_q && s1_read_q))
    else $error("read request lost before the RAM stage");

  // A stalled RAM stage must block new transfers, or its read data is lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while the RAM stage is stalled");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XOR frame receiver testbench
// Drives received bytes and table reads into the frame receiver, predicts each
// frame report and read reply, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_MODULES     = 8;
  localparam int FRAME_LEN       = 6;
  // A run is declared hung after this many cycles without any transfer on
  // either channel. The longest correct quiet stretch is the hold-off below.
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 150;
  // Results pass through the RAM read stage and the output register; this margin lets the pipeline settle.
  localparam int SETTLE_CYCLES   = 8;

  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN
  } rdy_mode_e;

  // One input item as the sender sees it.
  typedef struct packed {
    logic       action;
    logic [7:0] data;
    logic [1:0] tbl;
    logic [3:0] module_sel;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  xfrst_in_if  in_if();
  xfrst_out_if out_if();

  xor_frame_receiver_status_table #(
    .MODULE_COUNT(NUM_MODULES),
    .FRAME_LENGTH(FRAME_LEN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: the open frame and the four status tables. The tables
  // come out of reset empty, which the declarations below mirror.
  // --------------------------------------------------------------------------
  logic [7:0]  frame_buf [FRAME_LEN-1];
  int unsigned frame_pos = 0;
  bit          frame_is_open = 1'b0;
  bit          entry_valid [4][NUM_MODULES] = '{default: 1'b0};
  logic [7:0]  entry_cmd   [4][NUM_MODULES];
  logic [7:0]  entry_par   [4][NUM_MODULES];

  // Reports and read replies still owed by the block, oldest first.
  xfrst_pkg::result_t pending_reports [$];

  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;

  // Sender and receiver pacing, steered by the test tasks.
  int        burst_left    = 0;
  bit        sender_gaps   = 1'b0;
  rdy_mode_e rdy_mode      = RDY_ALWAYS;
  int        hold_request  = 0;
  int        hold_left     = 0;
  int        rdy_cycle     = 0;

  // Command byte to table: the three light commands share one table, and any
  // command that is not recognized lands in the state table.
  function automatic logic [1:0] table_for_command(input logic [7:0] cmd);
    case (cmd)
      xfrst_pkg::CMD_LIGHT_A, xfrst_pkg::CMD_LIGHT_B,
      xfrst_pkg::CMD_LIGHT_C:       return xfrst_pkg::TBL_LIGHT;
      xfrst_pkg::CMD_TIMEOUT:       return xfrst_pkg::TBL_TIMEOUT;
      xfrst_pkg::CMD_BRIGHTNESS:    return xfrst_pkg::TBL_BRIGHTNESS;
      default:                      return xfrst_pkg::TBL_STATE;
    endcase
  endfunction

  function automatic xfrst_pkg::result_t make_report(input xfrst_pkg::kind_e k,
                                                     input logic [7:0] id,
                                                     input logic [7:0] cmd,
                                                     input logic [7:0] par,
                                                     input logic [1:0] hit);
    xfrst_pkg::result_t r;
    r.kind           = k;
    r.module_id      = id;
    r.command_byte   = cmd;
    r.parameter_byte = par;
    r.table_hit      = hit;
    return r;
  endfunction

  // Advances the predicted block by one accepted item and queues the result
  // it causes, if any.
  function automatic void predict_reports(input request_t req);
    logic [7:0] sum;
    logic [1:0] tbl;
    int         idx;
    if (req.action == xfrst_pkg::ACT_READ) begin
      // A read never touches the open frame. IDs outside 1..NUM_MODULES and
      // entries never written both reply as an empty entry.
      idx = int'(req.module_sel) - 1;
      if (idx >= 0 && idx < NUM_MODULES && entry_valid[req.tbl][idx]) begin
        pending_reports.push_back(make_report(xfrst_pkg::KIND_READ, 8'(req.module_sel),
                                              entry_cmd[req.tbl][idx],
                                              entry_par[req.tbl][idx], req.tbl));
      end else begin
        pending_reports.push_back(make_report(xfrst_pkg::KIND_READ, 8'h00, 8'h00, 8'h00,
                                              req.tbl));
      end
    end else if (req.data == xfrst_pkg::HEADER_BYTE) begin
      // A header always opens a fresh frame. If one was open it is reported as
      // aborted with whatever ID, command and parameter it had collected,
      // even when the header took the place of the checksum.
      if (frame_is_open) begin
        pending_reports.push_back(make_report(xfrst_pkg::KIND_ABORTED, frame_buf[2],
                                              frame_buf[3], frame_buf[4],
                                              xfrst_pkg::TBL_LIGHT));
      end
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;
      frame_buf[0]  = xfrst_pkg::HEADER_BYTE;
      frame_pos     = 1;
      frame_is_open = 1'b1;
    end else if (frame_is_open) begin
      if (frame_pos < FRAME_LEN - 1) begin
        frame_buf[frame_pos] = req.data;
        frame_pos++;
      end else begin
        // Checksum position: XOR of every byte before it, header included.
        sum = 8'h00;
        foreach (frame_buf[i]) sum ^= frame_buf[i];
        frame_is_open = 1'b0;
        frame_pos     = 0;
        if (sum != req.data) begin
          pending_reports.push_back(make_report(xfrst_pkg::KIND_BAD_SUM, frame_buf[2],
                                                frame_buf[3], frame_buf[4],
                                                xfrst_pkg::TBL_LIGHT));
        end else if (frame_buf[2] >= 1 && frame_buf[2] <= NUM_MODULES) begin
          tbl = table_for_command(frame_buf[3]);
          idx = int'(frame_buf[2]) - 1;
          entry_valid[tbl][idx] = 1'b1;
          entry_cmd[tbl][idx]   = frame_buf[3];
          entry_par[tbl][idx]   = frame_buf[4];
          pending_reports.push_back(make_report(xfrst_pkg::KIND_STORED, frame_buf[2],
                                                frame_buf[3], frame_buf[4], tbl));
        end else begin
          pending_reports.push_back(make_report(xfrst_pkg::KIND_BAD_ID, frame_buf[2],
                                                frame_buf[3], frame_buf[4],
                                                xfrst_pkg::TBL_LIGHT));
        end
      end
    end
    // A byte with no frame open is dropped without a result.
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length; between bursts valid may
  // drop for a random gap. Valid stays high from one item to the next inside
  // a burst, where it is set once per item. Ready is sampled on the falling
  // edge, where every signal is settled, and the transfer counts at the
  // rising edge that follows.
  // --------------------------------------------------------------------------
  task automatic send_item(input request_t req);
    int gap;
    bit taken;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.action      <= req.action;
    in_if.byte_in     <= req.data;
    in_if.read_table  <= req.tbl;
    in_if.read_module <= req.module_sel;
    do begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end while (!taken);
    predict_reports(req);
    items_sent++;
  endtask

  // The fields that an action ignores still carry random values.
  task automatic send_byte(input logic [7:0] data);
    request_t req;
    req.action     = xfrst_pkg::ACT_BYTE;
    req.data       = data;
    req.tbl        = 2'($urandom);
    req.module_sel = 4'($urandom);
    send_item(req);
  endtask

  task automatic send_read(input logic [1:0] tbl, input logic [3:0] module_sel);
    request_t req;
    req.action     = xfrst_pkg::ACT_READ;
    req.data       = 8'($urandom);
    req.tbl        = tbl;
    req.module_sel = module_sel;
    send_item(req);
  endtask

  // Mostly valid module IDs, now and then anything the 4-bit field can hold.
  task automatic send_random_read();
    logic [3:0] module_sel;
    if ($urandom_range(0, 99) < 85) begin
      module_sel = 4'($urandom_range(1, NUM_MODULES));
    end else begin
      module_sel = 4'($urandom);
    end
    send_read(2'($urandom), module_sel);
  endtask

  // Sends one complete frame. The byte after the header carries no meaning
  // here and is random. With corrupt set, the checksum is spoiled by a
  // nonzero XOR; with mixed_reads set, table reads may slip in before any byte.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] cmd,
                            input logic [7:0] par, input bit corrupt,
                            input bit mixed_reads);
    logic [7:0] frame_seq [FRAME_LEN];
    frame_seq[0] = xfrst_pkg::HEADER_BYTE;
    frame_seq[1] = 8'($urandom);
    frame_seq[2] = id;
    frame_seq[3] = cmd;
    frame_seq[4] = par;
    frame_seq[5] = frame_seq[0] ^ frame_seq[1] ^ id ^ cmd ^ par;
    if (corrupt) frame_seq[5] ^= 8'($urandom_range(1, 255));
    foreach (frame_seq[i]) begin
      if (mixed_reads && $urandom_range(0, 99) < 8) send_random_read();
      send_byte(frame_seq[i]);
    end
  endtask

  // Drops valid and holds off until every owed result has been checked, then
  // lets the pipeline settle.
  task automatic wait_for_reports();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Ready is low during reset and then follows the current mode,
  // except while a hold-off is running: then it stays low for the requested
  // number of cycles, counted here rather than in the test that asked for it.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rdy_cycle++;
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (rst_ni !== 1'b1) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rdy_mode)
        RDY_ALWAYS:  out_if.ready <= 1'b1;
        RDY_RANDOM:  out_if.ready <= ($urandom_range(0, 99) < 65);
        default:     out_if.ready <= ((rdy_cycle % 11) >= 4);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker and watchdog. On the falling edge every signal is stable,
  // so a valid and ready pair seen here is exactly the transfer that happens
  // at the next rising edge.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    xfrst_pkg::result_t seen;
    xfrst_pkg::result_t want;
    if (rst_ni === 1'b1) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_if.valid && out_if.ready) begin
        seen = make_report(xfrst_pkg::kind_e'(out_if.kind), out_if.module_id,
                           out_if.command_byte, out_if.parameter_byte,
                           out_if.table_hit);
        if (pending_reports.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result kind %0d id %02h cmd %02h par %02h tbl %0d",
                   $time, seen.kind, seen.module_id, seen.command_byte,
                   seen.parameter_byte, seen.table_hit);
        end else begin
          want = pending_reports.pop_front();
          if (seen !== want) begin
            error_count++;
            $display("%0t: expected kind %0d id %02h cmd %02h par %02h tbl %0d", $time,
                     want.kind, want.module_id, want.command_byte, want.parameter_byte,
                     want.table_hit);
            $display("%0t: actual   kind %0d id %02h cmd %02h par %02h tbl %0d", $time,
                     seen.kind, seen.module_id, seen.command_byte, seen.parameter_byte,
                     seen.table_hit);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, pending_reports.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Right after reset every table reads empty, IDs out of range read empty,
  // and a byte with no frame open is dropped.
  task automatic test_empty_reads();
    send_read(xfrst_pkg::TBL_LIGHT, 4'd1);
    send_read(xfrst_pkg::TBL_STATE, 4'd8);
    send_read(xfrst_pkg::TBL_TIMEOUT, 4'd0);
    send_read(xfrst_pkg::TBL_BRIGHTNESS, 4'd15);
    send_byte(8'h55);
    wait_for_reports();
  endtask

  // A good frame for the highest module ID is stored, a read in the middle of
  // the frame leaves it intact, and a read right after the frame sees it.
  task automatic test_store_and_read();
    send_byte(xfrst_pkg::HEADER_BYTE);
    send_byte(8'h00);
    send_byte(8'd8);
    send_byte(xfrst_pkg::CMD_BRIGHTNESS);
    send_read(xfrst_pkg::TBL_BRIGHTNESS, 4'd8);
    send_byte(8'hFF);
    send_byte(xfrst_pkg::HEADER_BYTE ^ 8'd8 ^ xfrst_pkg::CMD_BRIGHTNESS ^ 8'hFF);
    send_read(xfrst_pkg::TBL_BRIGHTNESS, 4'd8);
    wait_for_reports();
  endtask

  // A header cuts a short frame, then a good frame with an ID out of range;
  // a header in the checksum position aborts a full frame, and the frame it
  // opens ends with a bad checksum.
  task automatic test_aborts_and_errors();
    logic [7:0] seq [11];
    seq = '{xfrst_pkg::HEADER_BYTE, 8'h01, 8'h03, xfrst_pkg::CMD_LIGHT_C, 8'h01,
            xfrst_pkg::HEADER_BYTE, 8'h00, 8'h03, xfrst_pkg::CMD_LIGHT_C, 8'h01, 8'h5A};
    send_byte(xfrst_pkg::HEADER_BYTE);
    send_byte(8'h12);
    send_byte(8'h09);
    send_frame(8'h09, xfrst_pkg::CMD_TIMEOUT, 8'h80, 1'b0, 1'b0);
    foreach (seq[i]) send_byte(seq[i]);
    wait_for_reports();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the block fills up and must stall its input.
  task automatic test_back_pressure();
    rdy_mode    = RDY_ALWAYS;
    sender_gaps = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (16) send_random_read();
    send_frame(8'($urandom_range(1, NUM_MODULES)), xfrst_pkg::CMD_LIGHT_B, 8'($urandom),
               1'b0, 1'b0);
    wait_for_reports();
  endtask

  // Random traffic in segments, each with its own receiver mode and with or
  // without sender gaps. Most of it is whole frames with random content; the
  // rest is reads, stray bytes and frames cut short by the next header.
  task automatic test_random_traffic(input int unsigned count);
    logic [7:0]  known_cmds [5];
    int unsigned stop_at;
    int unsigned seg_end;
    int          sel;
    logic [7:0]  id;
    logic [7:0]  cmd;
    known_cmds = '{xfrst_pkg::CMD_LIGHT_A, xfrst_pkg::CMD_LIGHT_B, xfrst_pkg::CMD_TIMEOUT,
                   xfrst_pkg::CMD_LIGHT_C, xfrst_pkg::CMD_BRIGHTNESS};
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      rdy_mode    = rdy_mode_e'($urandom_range(0, 2));
      sender_gaps = 1'($urandom);
      seg_end     = items_sent + $urandom_range(30, 90);
      while (items_sent < seg_end && items_sent < stop_at) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          if ($urandom_range(0, 99) < 80) begin
            id = 8'($urandom_range(1, NUM_MODULES));
          end else begin
            id = 8'($urandom);
          end
          sel = $urandom_range(0, 6);
          cmd = (sel < 5) ? known_cmds[sel] : 8'($urandom);
          send_frame(id, cmd, 8'($urandom), $urandom_range(0, 99) < 15, 1'b1);
        end else if (sel < 80) begin
          send_random_read();
        end else if (sel < 90) begin
          send_byte(8'($urandom));
        end else begin
          send_byte(xfrst_pkg::HEADER_BYTE);
          repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
        end
      end
    end
    wait_for_reports();
  endtask

  initial begin
    // Every block input starts at a known value; reset is held low and released once.
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.action      <= xfrst_pkg::ACT_BYTE;
    in_if.byte_in     <= 8'h00;
    in_if.read_table  <= xfrst_pkg::TBL_LIGHT;
    in_if.read_module <= 4'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_reads();
    test_store_and_read();
    test_aborts_and_errors();
    test_back_pressure();
    test_random_traffic(480);

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/xfrst_pkg.sv
design/xfrst_in_if.sv
design/xfrst_out_if.sv
design/xfrst_ram.sv
design/xor_frame_receiver_status_table.sv
verif/tb_top.sv
